>>> src/ramt_pkg.sv
package ramt_pkg;

    localparam int SIZE = 1024;
    localparam int LC_W = 11;
    localparam int LO_W = 10;
    localparam int HI_W = 11;
    localparam int VAL_W = 32;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic REG_LEAF_COUNT = 1'b0;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [LO_W-1:0]         index_lo;
        logic [HI_W-1:0]         index_hi;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] max_value;
        logic                    empty_range;
    } t_out_item;

endpackage

>>> src/range_add_range_max_tree_top.sv
// channel   | signals                               | transfer when
// in        | i_in_valid, o_in_ready, i_in          | i_in_valid && o_in_ready
// out       | o_out_valid, i_out_ready, o_out       | o_out_valid && i_out_ready
// config    | psel, penable, pwrite, paddr, pwdata  | psel && penable && pwrite
//
// one command at a time; on the single read and single write port of the two
// node memories a disjoint node takes S_ENTER and S_RET, a covered one adds
// S_TG1 (range add) or S_Q1 (query), a split node also S_PD1 to S_PD4, S_CONT
// and, for a range add or a point write, S_PU1 and S_PU2
// after reset both memories are cleared, no command taken
// a finished result waits in the output register; the next command is taken
// meanwhile and stalls only when it must hand over its own result
module range_add_range_max_tree_top
    import ramt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int NODES = 4 * SIZE;
    localparam int PW = $clog2(NODES);
    localparam int LW = $clog2(SIZE + 1);
    localparam int XW = (LW > HI_W) ? LW : HI_W;
    localparam int DEPTH = $clog2(SIZE) + 1;
    localparam int SPW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_ENTER, S_TG1, S_Q1, S_PD1, S_PD2, S_PD3, S_PD4,
        S_RET, S_CONT, S_PU1, S_PU2
    } t_state;

    typedef struct packed {
        logic [PW-1:0]    p;
        logic [XW-1:0]    l;
        logic [XW-1:0]    r;
        logic             ph;
        logic [VAL_W-1:0] acc;
        logic             fnd;
    } t_frame;

    t_state            r_state, n_state;
    t_frame            r_cur, n_cur;
    t_frame            r_stk [DEPTH];
    logic [SPW-1:0]    r_sp, n_sp;
    logic              push;
    t_frame            push_frame;
    logic [1:0]        r_cmd, n_cmd;
    logic [XW-1:0]     r_x, n_x, r_y, n_y;
    logic [VAL_W-1:0]  r_v, n_v;
    logic [VAL_W-1:0]  r_ret_val, n_ret_val;
    logic              r_ret_fnd, n_ret_fnd;
    logic [VAL_W-1:0]  r_pd, n_pd, r_a, n_a;
    logic [LC_W-1:0]   r_lc;
    logic [PW-1:0]     r_clr, n_clr;
    logic              r_ov, n_ov;
    t_out_item         r_out, n_out;

    logic              we_max, we_pend;
    logic [PW-1:0]     waddr, raddr;
    logic [VAL_W-1:0]  wd_max, wd_pend, rd_max, rd_pend;

    logic [XW-1:0]     lc_ext, n_leaf, in_x, in_y0, in_y;
    logic [XW:0]       lr_sum;
    logic [XW-1:0]     mid;
    logic [PW-1:0]     left_p, right_p;
    logic              disjoint, covered, start;
    logic [VAL_W-1:0]  m_acc;
    logic              m_fnd;
    t_frame            pop_frame;

    function automatic logic [VAL_W-1:0] smax(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b);
        return ($signed(a) > $signed(b)) ? a : b;
    endfunction

    ramt_ram #(.W(VAL_W), .D(NODES)) u_max_ram (
        .i_clk(i_clk), .i_we(we_max), .i_waddr(waddr), .i_wdata(wd_max),
        .i_raddr(raddr), .o_rdata(rd_max)
    );

    ramt_ram #(.W(VAL_W), .D(NODES)) u_pend_ram (
        .i_clk(i_clk), .i_we(we_pend), .i_waddr(waddr), .i_wdata(wd_pend),
        .i_raddr(raddr), .o_rdata(rd_pend)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out = r_out;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LEAF_COUNT) ? APB_DW'(r_lc) : '0;

    assign lc_ext = XW'(r_lc);
    assign n_leaf = (lc_ext == '0) ? XW'(1) :
                    (lc_ext > XW'(SIZE)) ? XW'(SIZE) : lc_ext;
    assign in_x = XW'(i_in.index_lo);
    assign in_y0 = XW'(i_in.index_hi);
    assign in_y = (i_in.cmd == CMD_WRITE) ? in_x + XW'(1) :
                  (in_y0 > n_leaf) ? n_leaf : in_y0;
    assign start = (i_in.cmd == CMD_WRITE) ? (in_x < n_leaf) :
                   ((i_in.cmd == CMD_ADD) || (i_in.cmd == CMD_QUERY)) && (in_x < in_y);

    assign lr_sum = {1'b0, r_cur.l} + {1'b0, r_cur.r};
    assign mid = lr_sum[XW:1];
    assign left_p = {r_cur.p[PW-2:0], 1'b0};
    assign right_p = {r_cur.p[PW-2:0], 1'b1};
    assign disjoint = (r_cur.l >= r_y) || (r_cur.r <= r_x);
    assign covered = (r_cur.l >= r_x) && (r_cur.r <= r_y);
    assign m_fnd = r_cur.fnd || r_ret_fnd;
    assign m_acc = !r_ret_fnd ? r_cur.acc :
                   r_cur.fnd ? smax(r_cur.acc, r_ret_val) : r_ret_val;
    assign pop_frame = r_stk[IW'(r_sp - SPW'(1))];

    always_comb begin
        n_state = r_state;
        n_cur = r_cur;
        n_sp = r_sp;
        push = 1'b0;
        push_frame = r_cur;
        n_cmd = r_cmd;
        n_x = r_x;
        n_y = r_y;
        n_v = r_v;
        n_ret_val = r_ret_val;
        n_ret_fnd = r_ret_fnd;
        n_pd = r_pd;
        n_a = r_a;
        n_clr = r_clr;
        n_ov = r_ov && !i_out_ready;
        n_out = r_out;
        we_max = 1'b0;
        we_pend = 1'b0;
        waddr = r_cur.p;
        raddr = r_cur.p;
        wd_max = '0;
        wd_pend = '0;
        unique case (r_state)
            S_CLR: begin
                we_max = 1'b1;
                we_pend = 1'b1;
                waddr = r_clr;
                n_clr = r_clr + PW'(1);
                if (r_clr == PW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_in.cmd;
                    n_x = in_x;
                    n_y = in_y;
                    n_v = i_in.value;
                    n_ret_fnd = 1'b0;
                    n_sp = '0;
                    n_cur = '{p: PW'(1), l: '0, r: n_leaf, ph: 1'b0, acc: '0, fnd: 1'b0};
                    n_state = start ? S_ENTER : S_RET;
                end
            end
            S_ENTER: begin
                if (disjoint) begin
                    n_ret_fnd = 1'b0;
                    n_state = S_RET;
                end else if (covered) begin
                    unique case (r_cmd)
                        CMD_WRITE: begin
                            we_max = 1'b1;
                            wd_max = r_v;
                            n_state = S_RET;
                        end
                        CMD_ADD: n_state = S_TG1;
                        default: n_state = S_Q1;
                    endcase
                end else begin
                    n_state = S_PD1;
                end
            end
            S_TG1: begin
                we_max = 1'b1;
                we_pend = 1'b1;
                wd_max = rd_max + r_v;
                wd_pend = rd_pend + r_v;
                n_state = S_RET;
            end
            S_Q1: begin
                n_ret_val = rd_max;
                n_ret_fnd = 1'b1;
                n_state = S_RET;
            end
            S_PD1: begin
                n_pd = rd_pend;
                raddr = left_p;
                n_state = S_PD2;
            end
            S_PD2: begin
                we_max = 1'b1;
                we_pend = 1'b1;
                waddr = left_p;
                wd_max = rd_max + r_pd;
                wd_pend = rd_pend + r_pd;
                raddr = right_p;
                n_state = S_PD3;
            end
            S_PD3: begin
                we_max = 1'b1;
                we_pend = 1'b1;
                waddr = right_p;
                wd_max = rd_max + r_pd;
                wd_pend = rd_pend + r_pd;
                n_state = S_PD4;
            end
            S_PD4: begin
                we_pend = 1'b1;
                push = 1'b1;
                n_sp = r_sp + SPW'(1);
                if (r_cmd == CMD_WRITE) begin
                    push_frame.ph = 1'b1;
                    if (r_x < mid) begin
                        n_cur = '{p: left_p, l: r_cur.l, r: mid, ph: 1'b0, acc: '0, fnd: 1'b0};
                    end else begin
                        n_cur = '{p: right_p, l: mid, r: r_cur.r, ph: 1'b0, acc: '0, fnd: 1'b0};
                    end
                end else begin
                    push_frame.ph = 1'b0;
                    n_cur = '{p: left_p, l: r_cur.l, r: mid, ph: 1'b0, acc: '0, fnd: 1'b0};
                end
                n_state = S_ENTER;
            end
            S_RET: begin
                if (r_sp == '0) begin
                    if (!r_ov || i_out_ready) begin
                        n_ov = 1'b1;
                        if (r_cmd == CMD_QUERY) begin
                            n_out.max_value = r_ret_fnd ? r_ret_val : '0;
                            n_out.empty_range = !r_ret_fnd;
                        end else begin
                            n_out.max_value = '0;
                            n_out.empty_range = 1'b0;
                        end
                        n_state = S_IDLE;
                    end
                end else begin
                    n_cur = pop_frame;
                    n_sp = r_sp - SPW'(1);
                    n_state = S_CONT;
                end
            end
            S_CONT: begin
                if (!r_cur.ph) begin
                    push = 1'b1;
                    push_frame.ph = 1'b1;
                    push_frame.acc = m_acc;
                    push_frame.fnd = m_fnd;
                    n_sp = r_sp + SPW'(1);
                    n_cur = '{p: right_p, l: mid, r: r_cur.r, ph: 1'b0, acc: '0, fnd: 1'b0};
                    n_state = S_ENTER;
                end else if (r_cmd == CMD_QUERY) begin
                    n_ret_val = m_acc;
                    n_ret_fnd = m_fnd;
                    n_state = S_RET;
                end else begin
                    raddr = left_p;
                    n_state = S_PU1;
                end
            end
            S_PU1: begin
                n_a = rd_max;
                raddr = right_p;
                n_state = S_PU2;
            end
            S_PU2: begin
                we_max = 1'b1;
                wd_max = smax(r_a, rd_max);
                n_state = S_RET;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_sp <= '0;
            r_ov <= 1'b0;
            r_lc <= LC_W'(SIZE);
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_sp <= n_sp;
            r_ov <= n_ov;
            if (psel && penable && pwrite && (paddr[2] == REG_LEAF_COUNT)) begin
                r_lc <= pwdata[LC_W-1:0];
            end
        end
        r_cur <= n_cur;
        r_cmd <= n_cmd;
        r_x <= n_x;
        r_y <= n_y;
        r_v <= n_v;
        r_ret_val <= n_ret_val;
        r_ret_fnd <= n_ret_fnd;
        r_pd <= n_pd;
        r_a <= n_a;
        r_out <= n_out;
        if (push) begin
            r_stk[IW'(r_sp)] <= push_frame;
        end
    end

endmodule

>>> src/ramt_ram.sv
module ramt_ram #(
    parameter int W = 32,
    parameter int D = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> src/ramt_chk.sv
module ramt_chk
    import ramt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out,
    input logic      pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result dropped before transfer");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.empty_range |-> o_out.max_value == '0)
        else $error("empty result with nonzero max");

    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second command taken while busy");

endmodule

bind range_add_range_max_tree_top ramt_chk u_ramt_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_out(o_out), .pready(pready)
);
